// ----- hdl/spq_pkg.sv -----
// ============================================================================
// spq_pkg - shared types and constants for the stable priority queue
// Entry layout, status codes, operation codes and cell control bundle.
// ============================================================================
package spq_pkg;

    // Queue geometry and field widths
    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int PRIO_W = 16;
    localparam int PAY_W  = 32;
    localparam int ST_W   = 2;

    // Operation codes carried on the operation field
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Status codes returned with every result beat
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One stored job
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [PAY_W-1:0]  payload;
    } t_entry;

    // Broadcast control to every cell, already qualified by full/empty
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

// ----- hdl/spq_cell.sv -----
// ============================================================================
// spq_cell - one slot of the sorted queue chain
// Holds one job. On push it keeps, takes the new job or takes its left
// neighbour's job; on pop it takes its right neighbour's job.
// ============================================================================
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occ,
    input  spq_pkg::t_entry    i_new,
    input  spq_pkg::t_entry    i_left,
    input  logic               i_left_lt,
    input  spq_pkg::t_entry    i_right,
    output spq_pkg::t_entry    o_entry,
    output logic               o_lt
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // New job belongs in front of this slot: slot empty or strictly lower priority.
    // Equal priority keeps the older job ahead.
    assign o_lt    = !i_occ || (r_entry.prio < i_new.prio);
    assign o_entry = r_entry;

    // Select the next slot content
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push && o_lt) begin
            n_entry = i_left_lt ? i_left : i_new;
        end else if (i_ctl.pop) begin
            n_entry = i_right;
        end
    end

    // Hold the job
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- hdl/stable_priority_queue_core.sv -----
// ============================================================================
// stable_priority_queue_core - bounded stable priority queue of jobs
// Jobs are kept sorted in a chain of cells, highest priority at the head,
// older jobs ahead of newer ones of equal priority. Pop takes the head.
// ============================================================================
//
//  channel   handshake        payload
//  -------   --------------   ------------------------------------------------
//  command   start / busy     i_operation, i_priority_req, i_payload
//  result    o_valid strobe   o_status, o_out_priority, o_out_payload,
//                             o_occupancy
//
//  A command beat is taken when start is high and busy is low; busy stays low.
//  Every cell compares the new priority with its own job in parallel and the
//  chain shifts by one place in the same edge, so one beat is taken per cycle.
//  The result beat appears on the cycle after the command, for one cycle.
//  Synchronous active-low reset empties the queue; no clearing pass is needed.
//  The result side cannot stall, so no result is ever held back.
//
module stable_priority_queue_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_operation,
    input  logic [spq_pkg::PRIO_W-1:0]  i_priority_req,
    input  logic [spq_pkg::PAY_W-1:0]   i_payload,
    output logic                        o_valid,
    output logic [spq_pkg::ST_W-1:0]    o_status,
    output logic [spq_pkg::PRIO_W-1:0]  o_out_priority,
    output logic [spq_pkg::PAY_W-1:0]   o_out_payload,
    output logic [spq_pkg::CNT_W-1:0]   o_occupancy
);

    localparam logic [spq_pkg::CNT_W-1:0] FULL_CNT = spq_pkg::CNT_W'(spq_pkg::DEPTH);

    logic                         r_valid;
    logic                         n_valid;
    spq_pkg::t_status             r_status;
    spq_pkg::t_status             n_status;
    logic [spq_pkg::PRIO_W-1:0]   r_prio;
    logic [spq_pkg::PRIO_W-1:0]   n_prio;
    logic [spq_pkg::PAY_W-1:0]    r_payload;
    logic [spq_pkg::PAY_W-1:0]    n_payload;
    logic [spq_pkg::CNT_W-1:0]    r_count;
    logic [spq_pkg::CNT_W-1:0]    n_count;

    logic                         w_accept;
    logic                         w_full;
    logic                         w_empty;
    spq_pkg::t_cell_ctl           w_ctl;
    spq_pkg::t_entry              w_new;
    spq_pkg::t_entry              w_entry [spq_pkg::DEPTH];
    logic                         w_lt    [spq_pkg::DEPTH];

    // Accept a command beat every cycle
    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == FULL_CNT);
    assign w_empty  = (r_count == '0);

    assign w_new.prio    = i_priority_req;
    assign w_new.payload = i_payload;

    // Qualify the broadcast shift controls
    assign w_ctl.push = w_accept && (i_operation == spq_pkg::OP_PUSH) && !w_full;
    assign w_ctl.pop  = w_accept && (i_operation == spq_pkg::OP_POP) && !w_empty;

    // Build the chain: head cell first, each cell linked to both neighbours
    for (genvar g = 0; g < spq_pkg::DEPTH; g++) begin : g_cell
        spq_pkg::t_entry w_left;
        spq_pkg::t_entry w_right;
        logic            w_left_lt;

        if (g == 0) begin : g_head
            assign w_left    = w_new;
            assign w_left_lt = 1'b0;
        end else begin : g_body
            assign w_left    = w_entry[g-1];
            assign w_left_lt = w_lt[g-1];
        end

        if (g == spq_pkg::DEPTH - 1) begin : g_tail
            assign w_right = w_entry[g];
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_occ     (r_count > spq_pkg::CNT_W'(g)),
            .i_new     (w_new),
            .i_left    (w_left),
            .i_left_lt (w_left_lt),
            .i_right   (w_right),
            .o_entry   (w_entry[g]),
            .o_lt      (w_lt[g])
        );
    end

    // Form the result beat and the next occupancy
    always_comb begin
        n_valid   = w_accept;
        n_status  = r_status;
        n_prio    = r_prio;
        n_payload = r_payload;
        n_count   = r_count;
        if (w_accept) begin
            n_status  = spq_pkg::ST_OK;
            n_prio    = '0;
            n_payload = '0;
            if (i_operation == spq_pkg::OP_PUSH) begin
                if (w_full) begin
                    n_status = spq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end else begin
                if (w_empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end else begin
                    n_prio    = w_entry[0].prio;
                    n_payload = w_entry[0].payload;
                    n_count   = r_count - 1'b1;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
        end
    end

    // Result payload registers
    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_prio    <= n_prio;
        r_payload <= n_payload;
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_out_priority = r_prio;
    assign o_out_payload  = r_payload;
    assign o_occupancy    = r_count;

    // Occupancy never exceeds the chain length
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue occupancy beyond depth");

    // A result beat only follows an accepted command beat
    a_valid_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept))
        else $error("result beat without command");

    // A full refusal leaves the queue full
    a_full_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_status == spq_pkg::ST_FULL)) |-> (r_count == FULL_CNT))
        else $error("full status with spare room");

    // A push moves occupancy up by one unless refused
    a_push_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.push |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not grow the queue");

    // Head two slots stay in priority order
    a_head_sorted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= spq_pkg::CNT_W'(2)) |-> (w_entry[0].prio >= w_entry[1].prio))
        else $error("head slots out of order");

endmodule
